// ===== rtl/sfc_pkg.sv =====
package sfc_pkg;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] REG_HEAD_DIR = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FAR_BORDER = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_CLOSE_BORDER = 2'd2;

	localparam logic [15:0] FAR_BORDER_RST = 16'd4000;
	localparam logic [15:0] CLOSE_BORDER_RST = 16'd1000;

	// Height thresholds per head direction: centre, little down, down, other.
	localparam int THR_W = 13;
	localparam logic [THR_W-1:0] STAND_THR [4] = '{13'd200, 13'd150, 13'd100, 13'd0};
	localparam logic [THR_W-1:0] FALL_THR [4] = '{13'd330, 13'd260, 13'd130, 13'd6660};

	localparam logic [31:0] TIME_WINDOW = 32'd30;
	localparam int SPEED_W = 16;
	localparam int OUT_DATA_W = 24;

	typedef struct packed {
		logic load;
		logic diff;
		logic sq_a;
		logic sq_b;
		logic root_step;
		logic acc;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/skeleton_fall_classifier_top.sv =====
// Each joint goes through load, difference, two squaring steps, a bit-serial square root
// yielding COORD_BITS + 1 result bits, and accumulate. After the last joint of a frame the
// block waits until the output register is free; the frame result then appears on m_axis and
// stays in the output register until taken. Reset is asynchronous and active low; it clears
// the frame flags (not recent_q, gap_ok_q) and speed sum and loads register defaults.
module skeleton_fall_classifier_top import sfc_pkg::*; #(
	parameter int COORD_BITS = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// From bit 0: prev_x, prev_y, now_x, now_y, depth_mm, frame_time, prior_frame_time,
	// query_time; then zero fill to whole bytes.
	input  logic [((4*COORD_BITS+112+7)/8)*8-1:0] s_axis_tdata,
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// From bit 0: standing, fallen, recent, speed_sum, speed_valid; then zero fill.
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sfc_ctrl #(
		.COORD_BITS(COORD_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sfc_dpath #(
		.COORD_BITS(COORD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata[4*COORD_BITS+111:0]),
		.in_last   (s_axis_tlast),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== rtl/sfc_ctrl.sv =====
module sfc_ctrl import sfc_pkg::*; #(
	parameter int COORD_BITS = 10
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam int ITER = COORD_BITS + 1;
	localparam int CNT_W = $clog2(ITER + 1);
	localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(ITER - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIFF = 3'd1;
	localparam logic [2:0] ST_SQA  = 3'd2;
	localparam logic [2:0] ST_SQB  = 3'd3;
	localparam logic [2:0] ST_ROOT = 3'd4;
	localparam logic [2:0] ST_ACC  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d = ST_SQA;
			end
			ST_SQA: begin
				cmd.sq_a = 1'b1;
				state_d = ST_SQB;
			end
			ST_SQB: begin
				cmd.sq_b = 1'b1;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (cnt_q == LAST_ITER)
					state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = stat.last ? ST_OUT : ST_IDLE;
			end
			ST_OUT: begin
				// Wait until the output register is free before the frame result goes out.
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROOT)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

endmodule

// ===== rtl/sfc_dpath.sv =====
module sfc_dpath import sfc_pkg::*; #(
	parameter int COORD_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_ADDR_W-1:0]         cfg_addr,
	input  logic [CFG_DATA_W-1:0]         cfg_wdata,
	input  logic [4*COORD_BITS+111:0]     in_data,
	input  logic                          in_last,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [OUT_DATA_W-1:0]         out_data,
	input  dp_cmd_t                       cmd,
	output dp_stat_t                      stat
);

	localparam int C = COORD_BITS;
	localparam int CMP_W = (C > THR_W) ? C : THR_W;
	localparam int RAD_W = 2 * C + 2;
	localparam int ROOT_W = C + 1;
	localparam int REM_W = C + 3;
	localparam int REMS_W = C + 5;
	localparam int SUM_W = ((ROOT_W > SPEED_W) ? ROOT_W : SPEED_W) + 1;

	// Configuration
	logic [1:0]  head_q;
	logic [15:0] far_q;
	logic [15:0] close_q;

	// Captured joint
	logic [C-1:0] px_q, py_q, nx_q, ny_q;
	logic [15:0]  depth_q;
	logic [31:0]  ftime_q, ptime_q, qtime_q;
	logic         last_q;

	// Per-joint arithmetic
	logic [C-1:0]      dx_q, dy_q;
	logic              coords_ok_q;
	logic [2*C-1:0]    sq_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	// Frame state
	logic              any_high_q, any_low_q, any_far_q, any_close_q, any_stand_q;
	logic [SPEED_W-1:0] speed_q;
	logic              recent_q, gap_ok_q;

	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [CMP_W-1:0]  py_ext;
	logic [CMP_W-1:0]  sthr, fthr;
	logic [31:0]       tdiff, tgap;
	logic [2*C-1:0]    dx_sq, dy_sq;
	logic [REMS_W-1:0] rem_sh, trial;
	logic [SUM_W-1:0]  sum;
	logic              stand, fall;
	logic [SPEED_W-1:0] speed_out;

	assign py_ext = CMP_W'(py_q);
	assign sthr = CMP_W'(STAND_THR[head_q]);
	assign fthr = CMP_W'(FALL_THR[head_q]);
	assign tdiff = (ftime_q > qtime_q) ? (ftime_q - qtime_q) : (qtime_q - ftime_q);
	assign tgap = ftime_q - ptime_q;

	assign dx_sq = {{C{1'b0}}, dx_q} * {{C{1'b0}}, dx_q};
	assign dy_sq = {{C{1'b0}}, dy_q} * {{C{1'b0}}, dy_q};

	assign rem_sh = REMS_W'({rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]});
	assign trial = REMS_W'({root_q, 2'b01});

	assign sum = SUM_W'(speed_q) + SUM_W'(root_q);

	assign stand = recent_q && any_stand_q;
	assign fall = recent_q && !any_high_q && any_low_q && !any_far_q && !any_close_q;
	assign speed_out = gap_ok_q ? speed_q : '0;

	assign stat.last = last_q;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			far_q <= FAR_BORDER_RST;
			close_q <= CLOSE_BORDER_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_HEAD_DIR:     head_q <= cfg_wdata[1:0];
				REG_FAR_BORDER:   far_q <= cfg_wdata[15:0];
				REG_CLOSE_BORDER: close_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= in_data[C-1:0];
			py_q <= in_data[2*C-1:C];
			nx_q <= in_data[3*C-1:2*C];
			ny_q <= in_data[4*C-1:3*C];
			depth_q <= in_data[4*C+15:4*C];
			ftime_q <= in_data[4*C+47:4*C+16];
			ptime_q <= in_data[4*C+79:4*C+48];
			qtime_q <= in_data[4*C+111:4*C+80];
			last_q <= in_last;
		end
		if (cmd.diff) begin
			dx_q <= (px_q > nx_q) ? (px_q - nx_q) : (nx_q - px_q);
			dy_q <= (py_q > ny_q) ? (py_q - ny_q) : (ny_q - py_q);
			coords_ok_q <= (px_q != '0) && (py_q != '0) && (nx_q != '0) && (ny_q != '0);
			recent_q <= (tdiff <= TIME_WINDOW);
			gap_ok_q <= (tgap <= TIME_WINDOW);
		end
		if (cmd.sq_a)
			sq_q <= dx_sq;
		if (cmd.sq_b) begin
			rad_q <= RAD_W'(sq_q) + RAD_W'(dy_sq);
			rem_q <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			// One result bit per cycle, taking the radicand two bits at a time.
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= REM_W'(rem_sh - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= REM_W'(rem_sh);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.emit)
			out_data_q <= OUT_DATA_W'({gap_ok_q, speed_out, recent_q, fall, stand});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_high_q <= 1'b0;
			any_low_q <= 1'b0;
			any_far_q <= 1'b0;
			any_close_q <= 1'b0;
			any_stand_q <= 1'b0;
			speed_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				any_high_q <= 1'b0;
				any_low_q <= 1'b0;
				any_far_q <= 1'b0;
				any_close_q <= 1'b0;
				any_stand_q <= 1'b0;
				speed_q <= '0;
			end else begin
				if (cmd.diff) begin
					if (py_q != '0 && py_ext < sthr)
						any_stand_q <= 1'b1;
					if (depth_q > far_q)
						any_far_q <= 1'b1;
					if (depth_q < close_q)
						any_close_q <= 1'b1;
					if (py_q != '0) begin
						if (py_ext >= fthr)
							any_low_q <= 1'b1;
						else
							any_high_q <= 1'b1;
					end
				end
				if (cmd.acc && coords_ok_q)
					speed_q <= (sum > SUM_W'({SPEED_W{1'b1}})) ? {SPEED_W{1'b1}}
						: sum[SPEED_W-1:0];
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule
